FILE: rtl/ksvg_pkg.sv
// Shared types, widths and helpers for the Kuhn simplex vertex generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ksvg_pkg;

  // Dimension of the cube that is triangulated.
  localparam int unsigned DIMENSION = 10;

  // Field widths.
  localparam int unsigned IDX_W   = 22;
  localparam int unsigned VNUM_W  = 4;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned AXIS_W  = 4;

  // Position index into the permutation.
  localparam int unsigned POS_W = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;

  // Reciprocal division: quotient = (x * ceil(2^DIV_SHIFT / d)) >> DIV_SHIFT.
  // This is exact for x below 2^IDX_W and every divisor below 16.
  localparam int unsigned DIV_SHIFT = IDX_W + 4;
  localparam int unsigned RECIP_W   = DIV_SHIFT;
  localparam int unsigned PROD_W    = IDX_W + RECIP_W;

  typedef logic [DIMENSION-1:0][AXIS_W-1:0] perm_t;

  // Payload of one unranking stage.
  typedef struct packed {
    logic [IDX_W-1:0] num;   // rank / (j-1)!
    logic [IDX_W-1:0] quo;   // rank / j!
    perm_t            perm;  // permutation after the swaps so far
  } unrank_t;

  // Identity permutation: position k holds axis k.
  function automatic perm_t identity_perm();
    perm_t p;
    for (int k = 0; k < DIMENSION; k++) begin
      p[k] = AXIS_W'(k);
    end
    return p;
  endfunction

endpackage

FILE: rtl/kuhn_simplex_vertex_generator.sv
// Top level: unranks a simplex index into an axis permutation and emits its vertices.
// Depends on ksvg_pkg and ksvg_serializer.
// Items pass the DIMENSION stage registers, then the serializer; vertices follow one per
// cycle while out_stall_i is low. The item rate is set by the vertex output channel; the
// DIMENSION-stage digit pipeline itself takes an item every cycle unless it is stalled.
// Reset is asynchronous and clears all valid bits; the pipeline payload is not reset.
`timescale 1ns / 1ps

module kuhn_simplex_vertex_generator import ksvg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [IDX_W-1:0]   simplex_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VNUM_W-1:0]  vertex_number_o,
  output logic [COORD_W-1:0] coordinates_o,
  output logic [AXIS_W-1:0]  axis_added_o,
  output logic               last_vertex_o
);

  unrank_t              stage_q [DIMENSION];
  unrank_t              stage_d [DIMENSION];
  logic [DIMENSION-1:0] valid_q;
  logic [DIMENSION-1:0] src_valid;
  logic [DIMENSION:0]   ready;
  logic                 ser_take;

  // Stage 0 input: division by two is a shift.
  always_comb begin
    stage_d[0].num  = simplex_index_i;
    stage_d[0].quo  = simplex_index_i >> 1;
    stage_d[0].perm = identity_perm();
  end

  // One factorial digit per stage: digit j is num - j * quo, the swap is applied,
  // and the next quotient comes from a reciprocal multiply in parallel.
  for (genvar i = 0; i < DIMENSION - 1; i++) begin : g_digit
    localparam int unsigned Base     = i + 2;
    localparam int unsigned NextBase = i + 3;
    localparam longint unsigned Recip =
      ((64'd1 << DIV_SHIFT) + NextBase - 1) / NextBase;

    logic [IDX_W-1:0]  base_mult;
    logic [IDX_W-1:0]  rem;
    logic [POS_W-1:0]  digit;
    logic [POS_W-1:0]  other;
    logic [PROD_W-1:0] recip_prod;

    always_comb begin
      base_mult  = stage_q[i].quo * IDX_W'(Base);
      rem        = stage_q[i].num - base_mult;
      digit      = rem[POS_W-1:0];
      other      = POS_W'(Base - 1) - digit;
      recip_prod = PROD_W'(stage_q[i].quo) * PROD_W'(Recip);

      stage_d[i+1].num  = stage_q[i].quo;
      stage_d[i+1].quo  = (NextBase <= DIMENSION) ? recip_prod[DIV_SHIFT +: IDX_W] : '0;
      stage_d[i+1].perm = stage_q[i].perm;
      stage_d[i+1].perm[Base-1] = stage_q[i].perm[other];
      stage_d[i+1].perm[other]  = stage_q[i].perm[Base-1];
    end
  end

  // Stall chain: a stage loads when it is empty or the stage after it loads.
  assign ready[DIMENSION] = ser_take;
  for (genvar k = 0; k < DIMENSION; k++) begin : g_stage
    assign ready[k]     = !valid_q[k] || ready[k+1];
    assign src_valid[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && src_valid[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign in_stall_o = !ready[0];

  // Vertex output.
  ksvg_serializer u_serializer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .perm_valid_i    (valid_q[DIMENSION-1]),
    .perm_i          (stage_q[DIMENSION-1].perm),
    .perm_take_o     (ser_take),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vertex_number_o (vertex_number_o),
    .coordinates_o   (coordinates_o),
    .axis_added_o    (axis_added_o),
    .last_vertex_o   (last_vertex_o)
  );

endmodule

FILE: rtl/ksvg_serializer.sv
// Vertex serializer: turns one finished permutation into DIMENSION+1 vertex items.
// Depends on ksvg_pkg for widths and the permutation type.
`timescale 1ns / 1ps

module ksvg_serializer import ksvg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               perm_valid_i,
  input  perm_t              perm_i,
  output logic               perm_take_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VNUM_W-1:0]  vertex_number_o,
  output logic [COORD_W-1:0] coordinates_o,
  output logic [AXIS_W-1:0]  axis_added_o,
  output logic               last_vertex_o
);

  localparam logic [VNUM_W-1:0] LastNum = VNUM_W'(DIMENSION);

  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  perm_t              perm_q, perm_d;
  logic [VNUM_W-1:0]  cnt_q, cnt_d;
  logic [COORD_W-1:0] coords_q, coords_d;

  logic               out_load;
  logic               emit;
  logic               emit_last;
  logic [AXIS_W-1:0]  emit_axis;
  logic [COORD_W-1:0] emit_coords;
  perm_t              perm_shift;

  // The output register loads when it is empty or its item is being taken.
  assign out_load  = !out_valid_q || !out_stall_i;
  assign emit      = busy_q && out_load;
  assign emit_last = emit && (cnt_q == LastNum);
  assign perm_take_o = !busy_q || emit_last;

  // Vertex 0 is the origin; later vertices add the axis at the head of the queue.
  always_comb begin
    if (cnt_q == '0) begin
      emit_axis   = '0;
      emit_coords = '0;
    end else begin
      emit_axis   = perm_q[0];
      emit_coords = coords_q | (COORD_W'(1) << perm_q[0]);
    end
    for (int k = 0; k < DIMENSION - 1; k++) begin
      perm_shift[k] = perm_q[k+1];
    end
    perm_shift[DIMENSION-1] = '0;
  end

  // Next state of the serializer.
  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    perm_d      = perm_q;
    cnt_d       = cnt_q;
    coords_d    = coords_q;
    if (out_load) begin
      out_valid_d = busy_q;
    end
    if (emit) begin
      cnt_d    = cnt_q + VNUM_W'(1);
      coords_d = emit_coords;
      if (cnt_q != '0) begin
        perm_d = perm_shift;
      end
    end
    if (perm_take_o) begin
      busy_d = perm_valid_i;
      if (perm_valid_i) begin
        perm_d   = perm_i;
        cnt_d    = '0;
        coords_d = '0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and output registers.
  always_ff @(posedge clk_i) begin
    perm_q   <= perm_d;
    cnt_q    <= cnt_d;
    coords_q <= coords_d;
    if (emit) begin
      vertex_number_o <= cnt_q;
      coordinates_o   <= emit_coords;
      axis_added_o    <= emit_axis;
      last_vertex_o   <= (cnt_q == LastNum);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/ksvg_checker.sv
// Port-level checks for the Kuhn simplex vertex generator, bound to the top level.
// Depends on ksvg_pkg and kuhn_simplex_vertex_generator.
`timescale 1ns / 1ps

module ksvg_checker import ksvg_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [VNUM_W-1:0]  vertex_number_o,
  input logic [COORD_W-1:0] coordinates_o,
  input logic [AXIS_W-1:0]  axis_added_o,
  input logic               last_vertex_o
);

  localparam logic [VNUM_W-1:0] LastNum = VNUM_W'(DIMENSION);

  // Vertices of one simplex follow each other without a gap and in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_vertex_o |=>
      out_valid_o && (vertex_number_o == $past(vertex_number_o) + VNUM_W'(1)))
    else $error("vertex sequence broken");

  // The last flag marks exactly the final vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_vertex_o == (vertex_number_o == LastNum)))
    else $error("last flag does not match vertex number");

  // Vertex 0 is the origin with no axis added.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (vertex_number_o == '0) |-> (coordinates_o == '0) && (axis_added_o == '0))
    else $error("vertex 0 is not the origin");

  // Coordinates only grow within a simplex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_vertex_o |=>
      ((coordinates_o & $past(coordinates_o)) == $past(coordinates_o)))
    else $error("coordinate bit lost between vertices");

endmodule

bind kuhn_simplex_vertex_generator ksvg_checker u_ksvg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .vertex_number_o (vertex_number_o),
  .coordinates_o   (coordinates_o),
  .axis_added_o    (axis_added_o),
  .last_vertex_o   (last_vertex_o)
);
